/* src/ple_pkg.sv */
`timescale 1ns / 1ps

package ple_pkg;

	localparam int CAPACITY = 128;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 8;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [CMP_W-1:0]         cmp_t;

	localparam cnt_t CNT_FULL = cnt_t'(CAPACITY);

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_GET    = 2'd2,
		ACT_LOCATE = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// what every cell does in a cycle
	typedef enum logic [1:0] {
		CO_HOLD = 2'd0,
		CO_INS  = 2'd1,
		CO_DEL  = 2'd2,
		CO_ROT  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		idx_t     pidx;
		idx_t     tail;
		data_t    wdata;
	} cell_ctl_t;

endpackage

/* src/ple_cell.sv */
`timescale 1ns / 1ps

module ple_cell (
	input  logic              clk,
	input  ple_pkg::idx_t     slot,
	input  ple_pkg::cell_ctl_t ctl,
	input  ple_pkg::data_t    left,
	input  ple_pkg::data_t    right,
	input  ple_pkg::data_t    head,
	output ple_pkg::data_t    data
);

	ple_pkg::data_t data_q;
	ple_pkg::data_t data_nxt;

	always_comb begin
		data_nxt = data_q;
		case (ctl.op)
			ple_pkg::CO_INS: begin
				if (slot > ctl.pidx) begin
					data_nxt = left;
				end else if (slot == ctl.pidx) begin
					data_nxt = ctl.wdata;
				end
			end
			ple_pkg::CO_DEL: begin
				if (slot >= ctl.pidx) begin
					data_nxt = right;
				end
			end
			ple_pkg::CO_ROT: begin
				// the live part of the row turns as a ring: last live cell takes the head
				if (slot == ctl.tail) begin
					data_nxt = head;
				end else begin
					data_nxt = right;
				end
			end
			default: begin
				data_nxt = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;

endmodule

/* src/ple_chain.sv */
`timescale 1ns / 1ps

module ple_chain (
	input  logic               clk,
	input  ple_pkg::cell_ctl_t ctl,
	output ple_pkg::data_t     head
);

	ple_pkg::data_t cell_data [ple_pkg::CAPACITY];

	for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
		ple_pkg::data_t left_w;
		ple_pkg::data_t right_w;

		if (i == 0) begin : g_first
			assign left_w = cell_data[i];
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == ple_pkg::CAPACITY - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		ple_cell u_cell (
			.clk   (clk),
			.slot  (ple_pkg::idx_t'(i)),
			.ctl   (ctl),
			.left  (left_w),
			.right (right_w),
			.head  (cell_data[0]),
			.data  (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

/* src/positional_list_engine_unit.sv */
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells, one entry per
// cell, positions counting from 1. One request is in work at a time; in_stall is high
// while it runs. Insert shifts the cells in the accept cycle, then goes to the done
// state. Get and locate turn the live part of the row once through the head cell, one
// entry per cycle, which restores the list. Delete runs that lap and then a shift.
// A request with a bad position, an insert into a full list and a locate on an empty
// list go straight to the done state. The result sits in an output register, so the next
// request is taken while it waits, but a new result waits until the previous one has
// been taken.
module positional_list_engine_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            action,
	input  ple_pkg::pos_t         position,
	input  ple_pkg::data_t        value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output ple_pkg::data_t        read_value,
	output ple_pkg::pos_t         found_position,
	output ple_pkg::pos_t         entry_count
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t              state_q;
	ple_pkg::cnt_t       cnt_q;
	logic                ovalid_q;

	ple_pkg::act_t       act_q;
	ple_pkg::idx_t       pidx_q;
	ple_pkg::idx_t       k_q;
	ple_pkg::data_t      val_q;
	ple_pkg::status_t    res_status_q;
	ple_pkg::data_t      res_rd_q;
	ple_pkg::pos_t       res_fpos_q;

	ple_pkg::status_t    out_status_q;
	ple_pkg::data_t      out_rd_q;
	ple_pkg::pos_t       out_fpos_q;
	ple_pkg::pos_t       out_cnt_q;

	ple_pkg::cell_ctl_t  ctl;
	ple_pkg::data_t      head;
	ple_pkg::idx_t       in_pidx;
	ple_pkg::idx_t       tail;
	ple_pkg::cmp_t       pos_c;
	ple_pkg::cmp_t       cnt_c;
	logic                ins_ok;
	logic                rd_ok;
	logic                full;
	logic                scan_last;
	logic                slot_free;

	assign pos_c     = ple_pkg::cmp_t'(position);
	assign cnt_c     = ple_pkg::cmp_t'(cnt_q);
	assign ins_ok    = (position != '0) && (pos_c <= cnt_c + ple_pkg::cmp_t'(1));
	assign rd_ok     = (position != '0) && (pos_c <= cnt_c);
	assign full      = (cnt_q == ple_pkg::CNT_FULL);
	assign in_pidx   = ple_pkg::idx_t'(position - ple_pkg::pos_t'(1));
	assign tail      = ple_pkg::idx_t'(cnt_q - ple_pkg::cnt_t'(1));
	assign scan_last = (k_q == tail);
	assign slot_free = !ovalid_q || !out_stall;

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = ovalid_q;
	assign status         = out_status_q;
	assign read_value     = out_rd_q;
	assign found_position = out_fpos_q;
	assign entry_count    = out_cnt_q;

	always_comb begin
		ctl.op    = ple_pkg::CO_HOLD;
		ctl.pidx  = pidx_q;
		ctl.tail  = tail;
		ctl.wdata = value;
		case (state_q)
			S_IDLE: begin
				ctl.pidx = in_pidx;
				if (in_valid && (action == ple_pkg::ACT_INSERT) && ins_ok && !full) begin
					ctl.op = ple_pkg::CO_INS;
				end
			end
			S_SCAN: begin
				ctl.op = ple_pkg::CO_ROT;
			end
			S_SHIFT: begin
				ctl.op = ple_pkg::CO_DEL;
			end
			default: begin
				ctl.op = ple_pkg::CO_HOLD;
			end
		endcase
	end

	ple_chain u_chain (
		.clk  (clk),
		.ctl  (ctl),
		.head (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall && (state_q != S_DONE)) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (action)
							ple_pkg::ACT_INSERT: begin
								state_q <= S_DONE;
								if (ins_ok && !full) begin
									cnt_q <= cnt_q + ple_pkg::cnt_t'(1);
								end
							end
							ple_pkg::ACT_DELETE, ple_pkg::ACT_GET: begin
								state_q <= rd_ok ? S_SCAN : S_DONE;
							end
							default: begin
								state_q <= (cnt_q != '0) ? S_SCAN : S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= (act_q == ple_pkg::ACT_DELETE) ? S_SHIFT : S_DONE;
					end
				end
				S_SHIFT: begin
					cnt_q   <= cnt_q - ple_pkg::cnt_t'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					act_q      <= ple_pkg::act_t'(action);
					pidx_q     <= in_pidx;
					val_q      <= value;
					k_q        <= '0;
					res_rd_q   <= '0;
					res_fpos_q <= '0;
					case (action)
						ple_pkg::ACT_INSERT: begin
							if (!ins_ok) begin
								res_status_q <= ple_pkg::ST_BADPOS;
							end else if (full) begin
								res_status_q <= ple_pkg::ST_FULL;
							end else begin
								res_status_q <= ple_pkg::ST_OK;
							end
						end
						ple_pkg::ACT_DELETE, ple_pkg::ACT_GET: begin
							res_status_q <= rd_ok ? ple_pkg::ST_OK : ple_pkg::ST_BADPOS;
						end
						default: begin
							res_status_q <= ple_pkg::ST_NOTFOUND;
						end
					endcase
				end
			end
			S_SCAN: begin
				// head holds entry k_q during this cycle
				k_q <= k_q + ple_pkg::idx_t'(1);
				if ((act_q != ple_pkg::ACT_LOCATE) && (k_q == pidx_q)) begin
					res_rd_q <= head;
				end
				if ((act_q == ple_pkg::ACT_LOCATE) && (res_status_q == ple_pkg::ST_NOTFOUND)
						&& (head == val_q)) begin
					res_status_q <= ple_pkg::ST_OK;
					res_fpos_q   <= ple_pkg::pos_t'(ple_pkg::cnt_t'(k_q) + ple_pkg::cnt_t'(1));
				end
			end
			S_DONE: begin
				if (slot_free) begin
					out_status_q <= res_status_q;
					out_rd_q     <= res_rd_q;
					out_fpos_q   <= res_fpos_q;
					out_cnt_q    <= ple_pkg::pos_t'(cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ple_pkg::CNT_FULL)
		else $error("entry count above capacity");

	a_scan_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ((cnt_q != '0) && (k_q <= tail)))
		else $error("lap runs past the live entries");

	a_del_shift: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && scan_last && (act_q == ple_pkg::ACT_DELETE))
			|=> (state_q == S_SHIFT))
		else $error("delete lap did not end in a shift");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ple_pkg::ST_FULL))
			|-> (entry_count == ple_pkg::pos_t'(ple_pkg::CAPACITY)))
		else $error("full status with list not full");

	a_fpos_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (found_position != '0)) |-> (status == ple_pkg::ST_OK))
		else $error("found position given without ok status");
`endif

endmodule
